// ----- sv/slec_pkg.sv -----
// shared types, codes and helpers for the string literal escape checker
// no dependencies

package slec_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX2    = 3'd2,
    MODE_UBRACE  = 3'd3,
    MODE_UDIGITS = 3'd4
  } scan_mode_e;

  typedef enum logic [2:0] {
    EV_OK      = 3'd0,
    EV_INVALID = 3'd1,
    EV_END     = 3'd2,
    EV_NEWLINE = 3'd3,
    EV_BAD_ESC = 3'd4
  } event_e;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned CODE_W = 21;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic [CODE_W+3:0] CODE_LIMIT = 25'h110000;
  localparam logic [CODE_W-1:0] SURR_LO    = 21'h00d800;
  localparam logic [CODE_W-1:0] SURR_HI    = 21'h00e000;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h37;
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// ----- sv/string_literal_escape_checker.sv -----
// string literal escape checker: top level, scan logic and result queue
// depends on slec_pkg
//
// channel   dir  tdata                           tuser    tlast
// s_axis    in   [7:0] data_byte                 is_end   -
// m_axis    out  [2:0] event_kind, position ...  -        last
//
// one input beat per cycle while s_axis_tready is high; each beat is scanned in the cycle it is taken
// and leaves zero, one or two result beats in a four entry output queue
// the queue drains one result per cycle while m_axis_tready is high, so two-result beats slow intake
// to the output rate; s_axis_tready is high while at least two entries are free
// reset clears scan state and empties the queue; payload needs no reset

module string_literal_escape_checker
  import slec_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            s_axis_tdata,   // data_byte
  input  logic                  s_axis_tuser,   // is_end
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic [((KIND_W+POSITION_WIDTH+7)/8)*8-1:0] m_axis_tdata, // event_kind, position, pad
  output logic                  m_axis_tlast,   // last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  localparam int unsigned PW    = POSITION_WIDTH;
  localparam int unsigned OUT_W = ((KIND_W + PW + 7) / 8) * 8;

  scan_mode_e        mode_q, mode_d;
  logic              had_q, had_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              saw_q, saw_d;
  logic [PW-1:0]     esc_q, esc_d;
  logic [PW-1:0]     cnt_q, cnt_d;

  event_e            r_kind [2];
  logic [PW-1:0]     r_pos  [2];
  logic [1:0]        r_n;

  event_e            kind_q [FIFO_DEPTH];
  logic [PW-1:0]     pos_q  [FIFO_DEPTH];
  logic              last_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  fill_q;

  logic              s_fire, m_fire;
  logic              consumed;
  logic [CODE_W+3:0] uval;
  logic [7:0]        b;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = fill_q <= CNT_W'(FIFO_DEPTH - 2);
  assign m_axis_tvalid = fill_q != '0;
  assign b             = s_axis_tdata;

  always_comb begin
    mode_d    = mode_q;
    had_d     = had_q;
    code_d    = code_q;
    saw_d     = saw_q;
    esc_d     = esc_q;
    cnt_d     = cnt_q;
    r_kind[0] = EV_OK;
    r_kind[1] = EV_OK;
    r_pos[0]  = '0;
    r_pos[1]  = '0;
    r_n       = 2'd0;
    consumed  = 1'b0;
    uval      = {code_q, 4'b0000} | {{CODE_W{1'b0}}, hex_val(b)};

    if (s_axis_tuser) begin
      if (mode_q != MODE_NORMAL) begin
        r_kind[0] = EV_BAD_ESC;
        r_pos[0]  = esc_q;
        r_n       = 2'd1;
      end
      r_kind[r_n[0]] = EV_END;
      r_pos[r_n[0]]  = cnt_q;
      r_n            = r_n + 2'd1;
      mode_d = MODE_NORMAL;
      had_d  = 1'b0;
      code_d = '0;
      saw_d  = 1'b0;
      esc_d  = '0;
      cnt_d  = '0;
    end else begin
      if (mode_q != MODE_NORMAL) begin
        consumed = 1'b1;
        case (mode_q)
          MODE_ESC: begin
            if (b inside {CH_T, CH_N, CH_R, CH_QUOTE, CH_APOS, CH_BSLASH}) begin
              mode_d = MODE_NORMAL;
            end else if (is_hex(b)) begin
              mode_d = MODE_HEX2;
            end else if (b == CH_U) begin
              mode_d = MODE_UBRACE;
            end else begin
              r_kind[0] = EV_BAD_ESC;
              r_pos[0]  = esc_q;
              r_n       = 2'd1;
              had_d     = 1'b1;
              mode_d    = MODE_NORMAL;
            end
          end
          MODE_HEX2: begin
            mode_d = MODE_NORMAL;
            if (!is_hex(b)) begin
              consumed  = 1'b0;
              r_kind[0] = EV_BAD_ESC;
              r_pos[0]  = esc_q;
              r_n       = 2'd1;
              had_d     = 1'b1;
            end
          end
          MODE_UBRACE: begin
            if (b == CH_LBRACE) begin
              mode_d = MODE_UDIGITS;
              code_d = '0;
              saw_d  = 1'b0;
            end else begin
              r_kind[0] = EV_BAD_ESC;
              r_pos[0]  = esc_q;
              r_n       = 2'd1;
              had_d     = 1'b1;
              mode_d    = MODE_NORMAL;
            end
          end
          MODE_UDIGITS: begin
            if (is_hex(b)) begin
              saw_d = 1'b1;
              if (uval >= CODE_LIMIT) begin
                code_d    = '0;
                r_kind[0] = EV_BAD_ESC;
                r_pos[0]  = esc_q;
                r_n       = 2'd1;
                had_d     = 1'b1;
                mode_d    = MODE_NORMAL;
              end else begin
                code_d = uval[CODE_W-1:0];
              end
            end else if (b == CH_RBRACE) begin
              if ((code_q >= SURR_LO && code_q < SURR_HI) || !saw_q) begin
                r_kind[0] = EV_BAD_ESC;
                r_pos[0]  = esc_q;
                r_n       = 2'd1;
                had_d     = 1'b1;
              end
              mode_d = MODE_NORMAL;
            end else begin
              consumed  = 1'b0;
              r_kind[0] = EV_BAD_ESC;
              r_pos[0]  = esc_q;
              r_n       = 2'd1;
              had_d     = 1'b1;
              mode_d    = MODE_NORMAL;
            end
          end
          default: begin
            consumed = 1'b0;
            mode_d   = MODE_NORMAL;
          end
        endcase
        if (consumed && cnt_q != '1) begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      if (!consumed) begin
        if (b == CH_QUOTE) begin
          r_kind[r_n[0]] = had_d ? EV_INVALID : EV_OK;
          r_pos[r_n[0]]  = cnt_d;
          r_n            = r_n + 2'd1;
          mode_d = MODE_NORMAL;
          had_d  = 1'b0;
          code_d = '0;
          saw_d  = 1'b0;
          esc_d  = '0;
          cnt_d  = '0;
        end else begin
          if (b == CH_NL) begin
            r_kind[r_n[0]] = EV_NEWLINE;
            r_pos[r_n[0]]  = cnt_d;
            r_n            = r_n + 2'd1;
            had_d          = 1'b1;
          end else if (b == CH_BSLASH) begin
            esc_d  = cnt_d;
            mode_d = MODE_ESC;
          end
          if (cnt_d != '1) begin
            cnt_d = cnt_d + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      had_q  <= 1'b0;
      code_q <= '0;
      saw_q  <= 1'b0;
      esc_q  <= '0;
      cnt_q  <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (s_fire) begin
        mode_q <= mode_d;
        had_q  <= had_d;
        code_q <= code_d;
        saw_q  <= saw_d;
        esc_q  <= esc_d;
        cnt_q  <= cnt_d;
        wr_q   <= wr_q + PTR_W'(r_n);
      end
      if (m_fire) begin
        rd_q <= rd_q + 1'b1;
      end
      fill_q <= fill_q + (s_fire ? CNT_W'(r_n) : '0) - CNT_W'(m_fire);
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (s_fire && r_n != 2'd0) begin
      kind_q[wr_q] <= r_kind[0];
      pos_q[wr_q]  <= r_pos[0];
      last_q[wr_q] <= r_n == 2'd1;
    end
    if (s_fire && r_n == 2'd2) begin
      kind_q[wr_q + 1'b1] <= r_kind[1];
      pos_q[wr_q + 1'b1]  <= r_pos[1];
      last_q[wr_q + 1'b1] <= 1'b1;
    end
  end

  assign m_axis_tdata = OUT_W'({pos_q[rd_q], kind_q[rd_q]});
  assign m_axis_tlast = last_q[rd_q];

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> mode_q == MODE_NORMAL && cnt_q == '0 && !had_q)
    else $error("end of input did not clear scan state");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'b0000, code_q} < CODE_LIMIT)
    else $error("unicode value out of range");
`endif

endmodule
